// ===== src/hlsd_pkg.sv =====
package hlsd_pkg;

	// level codes
	typedef logic [1:0] lvl_t;
	localparam lvl_t LVL_NONE   = 2'd0;
	localparam lvl_t LVL_SHORT  = 2'd1;
	localparam lvl_t LVL_MEDIUM = 2'd2;
	localparam lvl_t LVL_LONG   = 2'd3;

	// request operations
	typedef enum logic [1:0] {
		OP_UPDATE   = 2'd0,
		OP_LOCK_CUR = 2'd1,
		OP_LOCK_REQ = 2'd2,
		OP_CLEAR    = 2'd3
	} op_t;

	// configuration register indexes
	localparam int CFG_IDX_BITS = 3;
	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_SHORT_THR  = 3'd0,
		CFG_MEDIUM_THR = 3'd1,
		CFG_LONG_THR   = 3'd2,
		CFG_HYST       = 3'd3,
		CFG_PROMOTION  = 3'd4,
		CFG_DEMOTION   = 3'd5,
		CFG_MAX_INPUT  = 3'd6,
		CFG_PROF_READY = 3'd7
	} cfg_idx_t;

	// register reset values
	localparam int RST_SHORT_THR  = 2000;
	localparam int RST_MEDIUM_THR = 4000;
	localparam int RST_LONG_THR   = 6000;
	localparam int RST_HYST       = 250;
	localparam int RST_PROMOTION  = 1000;
	localparam int RST_DEMOTION   = 2000;
	localparam int RST_MAX_INPUT  = 5000;

	localparam int ACTION_BITS = 64;

	// classified request, front to back
	typedef struct packed {
		op_t  op;
		logic invalid;
		logic dur_ok;
		lvl_t plain;
		logic up_s;
		logic up_m;
		logic up_l;
		logic dn_s;
		logic dn_m;
		logic dn_l;
		lvl_t req;
		logic effort;
		logic fresh;
	} class_t;

	// one result
	typedef struct packed {
		lvl_t                   level;
		logic                   locked;
		lvl_t                   frozen;
		logic [ACTION_BITS-1:0] action;
	} res_t;

endpackage

// ===== src/hlsd_fifo.sv =====
module hlsd_fifo import hlsd_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// storage, no reset
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("fifo count beyond depth");

	a_count_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("fifo count did not grow on push");

	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("fifo full and empty together");

endmodule

// ===== src/hlsd_front.sv =====
module hlsd_front import hlsd_pkg::*; #(
	parameter int SPEED_BITS = 16,
	parameter int TIME_BITS  = 16
) (
	input  logic [1:0]            opcode,
	input  logic [SPEED_BITS-1:0] speed,
	input  logic                  speed_invalid,
	input  logic [TIME_BITS-1:0]  duration_ms,
	input  logic [1:0]            requested_level,
	input  logic                  effort_ready,
	input  logic                  telemetry_fresh,
	input  logic [SPEED_BITS-1:0] short_thr,
	input  logic [SPEED_BITS-1:0] medium_thr,
	input  logic [SPEED_BITS-1:0] long_thr,
	input  logic [SPEED_BITS-1:0] hyst,
	input  logic [TIME_BITS-1:0]  max_input,
	output class_t                cls
);

	logic [SPEED_BITS:0] s_w, sh_w, up_s_w, up_m_w, up_l_w;

	// widened sums: s < thr - h is tested as s + h < thr
	assign s_w    = {1'b0, speed};
	assign sh_w   = {1'b0, speed} + {1'b0, hyst};
	assign up_s_w = {1'b0, short_thr} + {1'b0, hyst};
	assign up_m_w = {1'b0, medium_thr} + {1'b0, hyst};
	assign up_l_w = {1'b0, long_thr} + {1'b0, hyst};

	// classify the request
	always_comb begin
		cls.op      = op_t'(opcode);
		cls.invalid = speed_invalid;
		cls.dur_ok  = (duration_ms != '0) && (duration_ms <= max_input);
		if (speed >= long_thr) begin
			cls.plain = LVL_LONG;
		end else if (speed >= medium_thr) begin
			cls.plain = LVL_MEDIUM;
		end else if (speed >= short_thr) begin
			cls.plain = LVL_SHORT;
		end else begin
			cls.plain = LVL_NONE;
		end
		cls.up_s   = (s_w >= up_s_w);
		cls.up_m   = (s_w >= up_m_w);
		cls.up_l   = (s_w >= up_l_w);
		cls.dn_s   = (sh_w < {1'b0, short_thr});
		cls.dn_m   = (sh_w < {1'b0, medium_thr});
		cls.dn_l   = (sh_w < {1'b0, long_thr});
		cls.req    = requested_level;
		cls.effort = effort_ready;
		cls.fresh  = telemetry_fresh;
	end

endmodule

// ===== src/hlsd_back.sv =====
module hlsd_back import hlsd_pkg::*; #(
	parameter int TIME_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  class_t                 cls,
	input  logic [TIME_BITS-1:0]   dur,
	input  logic [ACTION_BITS-1:0] action,
	output logic                   in_pop,
	input  logic                   out_full,
	output logic                   out_push,
	output res_t                   res,
	input  logic [TIME_BITS-1:0]   promotion,
	input  logic [TIME_BITS-1:0]   demotion,
	input  logic                   prof_ready
);

	lvl_t                   level_q, level_d;
	logic                   started_q, started_d;
	lvl_t                   cand_lvl_q, cand_lvl_d;
	logic [TIME_BITS-1:0]   cand_time_q, cand_time_d;
	logic                   locked_q, locked_d;
	lvl_t                   frozen_q, frozen_d;
	logic [ACTION_BITS-1:0] faction_q, faction_d;

	logic                   step;
	lvl_t                   band;
	lvl_t                   lock_lvl;
	logic [TIME_BITS-1:0]   base;
	logic [TIME_BITS:0]     sum;
	logic [TIME_BITS-1:0]   acc;
	logic [TIME_BITS-1:0]   need;

	assign step     = in_valid && !out_full;
	assign in_pop   = step;
	assign out_push = step;

	// Schmitt stage, relative to the present level
	always_comb begin
		case (level_q)
			LVL_NONE: begin
				band = cls.up_l ? LVL_LONG : cls.up_m ? LVL_MEDIUM :
					cls.up_s ? LVL_SHORT : LVL_NONE;
			end
			LVL_SHORT: begin
				band = cls.up_l ? LVL_LONG : cls.up_m ? LVL_MEDIUM :
					cls.dn_s ? LVL_NONE : LVL_SHORT;
			end
			LVL_MEDIUM: begin
				band = cls.up_l ? LVL_LONG :
					cls.dn_m ? (cls.dn_s ? LVL_NONE : LVL_SHORT) : LVL_MEDIUM;
			end
			default: begin
				band = !cls.dn_l ? LVL_LONG : cls.dn_s ? LVL_NONE :
					cls.dn_m ? LVL_SHORT : LVL_MEDIUM;
			end
		endcase
	end

	// dwell accumulation, saturated at the demotion time
	always_comb begin
		base = (cand_lvl_q == band) ? cand_time_q : '0;
		sum  = {1'b0, base} + {1'b0, dur};
		acc  = (sum > {1'b0, demotion}) ? demotion : sum[TIME_BITS-1:0];
		need = (band > level_q) ? promotion : demotion;
	end

	// lock level
	always_comb begin
		lock_lvl = (cls.op == OP_LOCK_CUR) ? level_q : cls.req;
		if (!(prof_ready && lock_lvl != LVL_NONE && cls.effort && cls.fresh)) begin
			lock_lvl = LVL_NONE;
		end
	end

	// next state
	always_comb begin
		level_d     = level_q;
		started_d   = started_q;
		cand_lvl_d  = cand_lvl_q;
		cand_time_d = cand_time_q;
		locked_d    = locked_q;
		frozen_d    = frozen_q;
		faction_d   = faction_q;
		if (step) begin
			case (cls.op)
				OP_UPDATE: begin
					if (!locked_q && prof_ready) begin
						if (cls.invalid) begin
							level_d     = LVL_NONE;
							started_d   = 1'b1;
							cand_lvl_d  = LVL_NONE;
							cand_time_d = '0;
						end else if (cls.dur_ok) begin
							if (!started_q) begin
								level_d   = cls.plain;
								started_d = 1'b1;
							end else if (band == level_q || acc >= need) begin
								level_d     = band;
								cand_lvl_d  = LVL_NONE;
								cand_time_d = '0;
							end else begin
								cand_lvl_d  = band;
								cand_time_d = acc;
							end
						end
					end
				end
				OP_LOCK_CUR, OP_LOCK_REQ: begin
					if (!locked_q) begin
						locked_d    = 1'b1;
						faction_d   = action;
						frozen_d    = lock_lvl;
						level_d     = lock_lvl;
						cand_lvl_d  = LVL_NONE;
						cand_time_d = '0;
					end
				end
				OP_CLEAR: begin
					level_d     = LVL_NONE;
					started_d   = 1'b0;
					cand_lvl_d  = LVL_NONE;
					cand_time_d = '0;
					locked_d    = 1'b0;
					frozen_d    = LVL_NONE;
					faction_d   = '0;
				end
				default: begin
				end
			endcase
		end
	end

	// result after this request
	always_comb begin
		res.level  = level_d;
		res.locked = locked_d;
		res.frozen = frozen_d;
		res.action = faction_d;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= LVL_NONE;
			started_q   <= 1'b0;
			cand_lvl_q  <= LVL_NONE;
			cand_time_q <= '0;
			locked_q    <= 1'b0;
			frozen_q    <= LVL_NONE;
			faction_q   <= '0;
		end else begin
			level_q     <= level_d;
			started_q   <= started_d;
			cand_lvl_q  <= cand_lvl_d;
			cand_time_q <= cand_time_d;
			locked_q    <= locked_d;
			frozen_q    <= frozen_d;
			faction_q   <= faction_d;
		end
	end

	a_lock_no_cand: assert property (@(posedge clk) disable iff (!arst_n)
		locked_q |-> (cand_lvl_q == LVL_NONE && cand_time_q == '0))
		else $error("candidate pending while locked");

	a_cand_differs: assert property (@(posedge clk) disable iff (!arst_n)
		(cand_time_q != '0) |-> (cand_lvl_q != level_q))
		else $error("candidate equals adopted level");

	a_unlocked_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!locked_q |-> (frozen_q == LVL_NONE && faction_q == '0))
		else $error("frozen data held while unlocked");

endmodule

// ===== src/hysteretic_level_selector_with_dwell.sv =====
// Channel  | Handshake          | Fields
// request  | push / full        | opcode speed speed_invalid duration_ms action_id
//          |                    | requested_level effort_ready telemetry_fresh
// result   | pop / empty        | current_level is_locked locked_level locked_action
// config   | wr_en wr_index     | wr_data (no wait, no read-back)
//
// One request per cycle sustained while the result queue is popped; each result
// is registered in the result queue before it shows on the result ports.
// The front classifies against the thresholds, a two-entry queue feeds the back,
// which updates the level state once per request into a two-entry result queue.
// full rises when both queues fill; the back stalls only on a full result queue.
// arst_n clears the level state and the queue pointers and loads the register reset values.
module hysteretic_level_selector_with_dwell import hlsd_pkg::*; #(
	parameter int SPEED_BITS = 16,
	parameter int TIME_BITS  = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [1:0]                      opcode,
	input  logic [SPEED_BITS-1:0]           speed,
	input  logic                            speed_invalid,
	input  logic [TIME_BITS-1:0]            duration_ms,
	input  logic [ACTION_BITS-1:0]          action_id,
	input  logic [1:0]                      requested_level,
	input  logic                            effort_ready,
	input  logic                            telemetry_fresh,
	output logic                            empty,
	input  logic                            pop,
	output logic [1:0]                      current_level,
	output logic                            is_locked,
	output logic [1:0]                      locked_level,
	output logic [ACTION_BITS-1:0]          locked_action,
	input  logic                            wr_en,
	input  logic [CFG_IDX_BITS-1:0]         wr_index,
	input  logic [((SPEED_BITS > TIME_BITS) ? SPEED_BITS : TIME_BITS)-1:0] wr_data
);

	localparam int MID_W = $bits(class_t) + TIME_BITS + ACTION_BITS;

	logic [SPEED_BITS-1:0] short_thr_q, medium_thr_q, long_thr_q, hyst_q;
	logic [TIME_BITS-1:0]  promotion_q, demotion_q, max_input_q;
	logic                  prof_ready_q;

	class_t                 cls_in, cls_out;
	logic [MID_W-1:0]       mid_wdata, mid_rdata;
	logic                   mid_empty, mid_pop;
	logic [TIME_BITS-1:0]   dur_out;
	logic [ACTION_BITS-1:0] act_out;
	logic                   res_full, res_push;
	res_t                   res_in, res_out;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_thr_q  <= SPEED_BITS'(RST_SHORT_THR);
			medium_thr_q <= SPEED_BITS'(RST_MEDIUM_THR);
			long_thr_q   <= SPEED_BITS'(RST_LONG_THR);
			hyst_q       <= SPEED_BITS'(RST_HYST);
			promotion_q  <= TIME_BITS'(RST_PROMOTION);
			demotion_q   <= TIME_BITS'(RST_DEMOTION);
			max_input_q  <= TIME_BITS'(RST_MAX_INPUT);
			prof_ready_q <= 1'b0;
		end else if (wr_en) begin
			case (cfg_idx_t'(wr_index))
				CFG_SHORT_THR:  short_thr_q  <= wr_data[SPEED_BITS-1:0];
				CFG_MEDIUM_THR: medium_thr_q <= wr_data[SPEED_BITS-1:0];
				CFG_LONG_THR:   long_thr_q   <= wr_data[SPEED_BITS-1:0];
				CFG_HYST:       hyst_q       <= wr_data[SPEED_BITS-1:0];
				CFG_PROMOTION:  promotion_q  <= wr_data[TIME_BITS-1:0];
				CFG_DEMOTION:   demotion_q   <= wr_data[TIME_BITS-1:0];
				CFG_MAX_INPUT:  max_input_q  <= wr_data[TIME_BITS-1:0];
				CFG_PROF_READY: prof_ready_q <= wr_data[0];
				default: begin
				end
			endcase
		end
	end

	// front: classify requests
	hlsd_front #(
		.SPEED_BITS(SPEED_BITS),
		.TIME_BITS (TIME_BITS)
	) u_front (
		.opcode         (opcode),
		.speed          (speed),
		.speed_invalid  (speed_invalid),
		.duration_ms    (duration_ms),
		.requested_level(requested_level),
		.effort_ready   (effort_ready),
		.telemetry_fresh(telemetry_fresh),
		.short_thr      (short_thr_q),
		.medium_thr     (medium_thr_q),
		.long_thr       (long_thr_q),
		.hyst           (hyst_q),
		.max_input      (max_input_q),
		.cls            (cls_in)
	);

	// queue between front and back
	assign mid_wdata = {cls_in, duration_ms, action_id};

	hlsd_fifo #(
		.WIDTH(MID_W),
		.DEPTH(2)
	) u_mid_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (mid_wdata),
		.full  (full),
		.pop   (mid_pop),
		.rdata (mid_rdata),
		.empty (mid_empty)
	);

	assign {cls_out, dur_out, act_out} = mid_rdata;

	// back: level state update
	hlsd_back #(
		.TIME_BITS(TIME_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (!mid_empty),
		.cls       (cls_out),
		.dur       (dur_out),
		.action    (act_out),
		.in_pop    (mid_pop),
		.out_full  (res_full),
		.out_push  (res_push),
		.res       (res_in),
		.promotion (promotion_q),
		.demotion  (demotion_q),
		.prof_ready(prof_ready_q)
	);

	// result queue
	hlsd_fifo #(
		.WIDTH($bits(res_t)),
		.DEPTH(2)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_in),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_out),
		.empty (empty)
	);

	assign current_level = res_out.level;
	assign is_locked     = res_out.locked;
	assign locked_level  = res_out.frozen;
	assign locked_action = res_out.action;

endmodule
